// File: design/fbvs_pkg.sv
// Package with shared types and constants of the vertex skinning block.
`timescale 1ns / 1ps
package fbvs_pkg;
  localparam int unsigned NumBonesDef      = 32;
  localparam int unsigned NumInfluencesDef = 4;
  localparam int unsigned BoneWords        = 12;
  localparam int unsigned RowWords         = 4;
  localparam int unsigned OneQ16           = 65536;

  typedef enum logic [1:0] {
    FUNC_LOAD      = 2'd0,
    FUNC_INFLUENCE = 2'd1,
    FUNC_VERTEX    = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_ROW  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// File: design/fbvs_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module fbvs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: design/four_bone_vertex_skinning.sv
// Top level of the four-influence linear blend skinning block.
`timescale 1ns / 1ps
// Load and influence items are handled in the idle state. A vertex item runs
// through ST_MAC and ST_ROW once per influence and then through ST_OUT before
// the next item can be taken. The bone palette sits in one single-port RAM,
// and each influence reads twelve matrix words one per cycle, through the
// registered RAM read, into a single 32x32 multiply-accumulate. ST_ROW adds
// the weighted three row terms of the influence into the sums, ST_OUT loads
// the output register, and the block then returns to idle. The result waits
// in an output register; a new item is taken once that register is empty or
// being drained.
module four_bone_vertex_skinning
  import fbvs_pkg::*;
#(
  parameter int unsigned NUM_BONES      = NumBonesDef,
  parameter int unsigned NUM_INFLUENCES = NumInfluencesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [4:0]         bone_index_i,
  input  logic [1:0]         matrix_row_i,
  input  logic [1:0]         matrix_col_i,
  input  logic signed [31:0] matrix_value_i,
  input  logic [1:0]         influence_slot_i,
  input  logic [15:0]        influence_weight_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               batch_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               out_last_o
);
  localparam int unsigned Depth = NUM_BONES * BoneWords;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IW    = (NUM_INFLUENCES > 1) ? $clog2(NUM_INFLUENCES) : 1;

  state_e state_q, state_d;
  logic [4:0]  inf_bone_q [NUM_INFLUENCES];
  logic [15:0] inf_wt_q   [NUM_INFLUENCES];
  logic [IW-1:0] k_q;
  logic [3:0]    w_q;       // word index within the bone, row*4+col
  logic          rd_vld_q;  // RAM data valid this cycle
  logic [1:0]    rd_col_q;
  logic [1:0]    rd_row_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic               last_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] term_q [3];
  logic signed [63:0] sum_q [3];
  logic               skip_q;
  logic               ovalid_q;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  logic          accept;
  logic          inf_slot_ok;

  fbvs_ram #(.Width(32), .Depth(Depth)) u_palette (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(matrix_value_i),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && (!ovalid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign inf_slot_ok = {30'd0, influence_slot_i} < NUM_INFLUENCES;

  logic [4:0] cur_bone;
  logic       cur_ok;
  assign cur_bone = inf_bone_q[k_q];
  assign cur_ok   = {27'd0, cur_bone} < NUM_BONES;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    if (state_q == ST_IDLE) begin
      ram_we = accept && (func_e'(func_i) == FUNC_LOAD)
               && ({27'd0, bone_index_i} < NUM_BONES) && (matrix_row_i != 2'd3);
      ram_addr = AW'({27'd0, bone_index_i} * BoneWords
                     + {30'd0, matrix_row_i} * RowWords + {30'd0, matrix_col_i});
    end else begin
      ram_addr = AW'({27'd0, cur_bone} * BoneWords + {28'd0, w_q});
    end
  end

  // Product of a matrix word and a position component (or 1.0 for column three), one per cycle.
  logic signed [31:0] pcomp;
  logic signed [63:0] prod, acc_sum, acc_in;
  logic               ovf;
  always_comb begin
    unique case (rd_col_q)
      2'd0:    pcomp = px_q;
      2'd1:    pcomp = py_q;
      2'd2:    pcomp = pz_q;
      default: pcomp = 32'sd65536;
    endcase
    prod    = $signed(ram_rdata) * pcomp;
    acc_in  = (rd_col_q == 2'd0) ? 64'sd0 : acc_q;
    acc_sum = acc_in + prod;
    ovf     = (acc_in[63] == prod[63]) && (acc_sum[63] != acc_in[63]);
  end

  logic signed [63:0] acc_sat;
  assign acc_sat = ovf ? (acc_in[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : acc_sum;

  // Weighted row term of the current influence, added into the sum.
  logic signed [48:0] wprod [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wprod[r] = term_q[r] * $signed({1'b0, inf_wt_q[k_q]});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && func_e'(func_i) == FUNC_VERTEX) state_d = ST_MAC;
      ST_MAC:  if (rd_vld_q && rd_row_q == 2'd2 && rd_col_q == 2'd3) state_d = ST_ROW;
      ST_ROW:  state_d = (32'(k_q) == NUM_INFLUENCES - 1) ? ST_OUT : ST_MAC;
      ST_OUT:  if (!ovalid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      k_q      <= '0;
      w_q      <= '0;
      rd_vld_q <= 1'b0;
      for (int i = 0; i < NUM_INFLUENCES; i++) begin
        inf_bone_q[i] <= '0;
        inf_wt_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && (!ovalid_q || out_ready_i)) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      rd_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && func_e'(func_i) == FUNC_INFLUENCE && inf_slot_ok) begin
            inf_bone_q[IW'(influence_slot_i)] <= bone_index_i;
            inf_wt_q[IW'(influence_slot_i)]   <= influence_weight_i;
          end
          k_q <= '0;
          w_q <= '0;
        end
        ST_MAC: begin
          if (w_q != 4'd12) begin
            rd_vld_q <= 1'b1;
            w_q      <= w_q + 4'd1;
          end
        end
        ST_ROW: begin
          w_q <= '0;
          k_q <= k_q + IW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && func_e'(func_i) == FUNC_VERTEX) begin
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      last_q <= batch_end_i;
      for (int r = 0; r < 3; r++) sum_q[r] <= '0;
    end
    rd_col_q <= w_q[1:0];
    rd_row_q <= w_q[3:2];
    if (state_q == ST_MAC && w_q == 4'd0) skip_q <= !cur_ok;
    if (rd_vld_q) begin
      acc_q <= acc_sat;
      if (rd_col_q == 2'd3) begin
        term_q[rd_row_q] <= sat32(acc_sat >>> 16);
      end
    end
    if (state_q == ST_ROW && !skip_q) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= sum_q[r] + 64'(wprod[r] >>> 15);
      end
    end
    if (state_q == ST_OUT && (!ovalid_q || out_ready_i)) begin
      out_x_o    <= sat32(sum_q[0]);
      out_y_o    <= sat32(sum_q[1]);
      out_z_o    <= sat32(sum_q[2]);
      out_last_o <= last_q;
    end
  end
endmodule

// File: dv/four_bone_vertex_skinning_tb.sv
// Self-checking testbench of the four-influence vertex skinning block.
`timescale 1ns / 1ps
module four_bone_vertex_skinning_tb;
  import fbvs_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainWait  = 80;

  typedef struct {
    func_e              func;
    logic [4:0]         bone;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] mval;
    logic [1:0]         slot;
    logic [15:0]        wt;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               last;
  } skin_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } skin_out_t;

  typedef struct {
    skin_item_t item;
    bit         typed;
    skin_out_t  want;
  } skin_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  func_e              func = FUNC_NONE;
  logic [4:0]         bone_index = '0;
  logic [1:0]         matrix_row = '0;
  logic [1:0]         matrix_col = '0;
  logic signed [31:0] matrix_value = '0;
  logic [1:0]         influence_slot = '0;
  logic [15:0]        influence_weight = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic               batch_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               out_last;

  four_bone_vertex_skinning dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (func),
    .bone_index_i      (bone_index),
    .matrix_row_i      (matrix_row),
    .matrix_col_i      (matrix_col),
    .matrix_value_i    (matrix_value),
    .influence_slot_i  (influence_slot),
    .influence_weight_i(influence_weight),
    .pos_x_i           (pos_x),
    .pos_y_i           (pos_y),
    .pos_z_i           (pos_z),
    .batch_end_i       (batch_end),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_x_o           (out_x),
    .out_y_o           (out_y),
    .out_z_o           (out_z),
    .out_last_o        (out_last)
  );

  // Predictor state: palette, influence pairs.
  logic signed [31:0] palette [NumBonesDef*BoneWords];
  logic [4:0]         infl_bone [NumInfluencesDef];
  logic [15:0]        infl_wt [NumInfluencesDef];

  skin_out_t pending_vertices[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          hold_req = 1'b0;
  bit          send_burst = 1'b0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // One row of M * (x, y, z, 1): saturating 64-bit sum, floored to Q16.16.
  function automatic longint bone_row(input int b, input int r, input longint px,
                                      input longint py, input longint pz);
    longint             pv [4];
    longint             acc;
    longint             prod;
    logic signed [64:0] s;
    pv[0] = px;
    pv[1] = py;
    pv[2] = pz;
    pv[3] = longint'(OneQ16);
    acc = 0;
    for (int c = 0; c < 4; c++) begin
      prod = longint'(palette[b*BoneWords + r*RowWords + c]) * pv[c];
      s = {acc[63], acc} + {prod[63], prod};
      if (s[64] != s[63]) acc = s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
      else acc = s[63:0];
    end
    return longint'(clamp32(acc >>> 16));
  endfunction

  // Applies one item to the predicted state; returns 1 when it yields a result.
  function automatic bit skin_vertex(input skin_item_t it, output skin_out_t res);
    longint sum [3];
    longint w;
    res = '{default: '0};
    case (it.func)
      FUNC_LOAD: begin
        if (it.row < 2'd3) palette[it.bone*BoneWords + it.row*RowWords + it.col] = it.mval;
        return 1'b0;
      end
      FUNC_INFLUENCE: begin
        infl_bone[it.slot] = it.bone;
        infl_wt[it.slot] = it.wt;
        return 1'b0;
      end
      FUNC_VERTEX: begin
        sum = '{0, 0, 0};
        for (int k = 0; k < NumInfluencesDef; k++) begin
          w = longint'({48'd0, infl_wt[k]});
          for (int r = 0; r < 3; r++)
            sum[r] += (bone_row(int'(infl_bone[k]), r, it.px, it.py, it.pz) * w) >>> 15;
        end
        res.x = clamp32(sum[0]);
        res.y = clamp32(sum[1]);
        res.z = clamp32(sum[2]);
        res.last = it.last;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0, 1, 2: return $signed($urandom_range(0, 262143)) - 131072;
      3: return $urandom();
      4: return 32'sh7FFFFFFF;
      default: return ($urandom_range(0, 1) != 0) ? 32'sh80000000 : -32'sd1;
    endcase
  endfunction

  function automatic skin_item_t rand_item(input func_e f);
    skin_item_t it;
    it.func = f;
    it.bone = 5'($urandom());
    it.row = 2'($urandom());
    it.col = 2'($urandom());
    it.mval = rand_q16();
    it.slot = 2'($urandom());
    case ($urandom_range(0, 7))
      0: it.wt = 16'd0;
      1: it.wt = 16'd32768;
      2: it.wt = 16'($urandom_range(32769, 65535));
      default: it.wt = 16'($urandom_range(0, 32768));
    endcase
    it.px = rand_q16();
    it.py = rand_q16();
    it.pz = rand_q16();
    it.last = 1'($urandom());
    return it;
  endfunction

  function automatic skin_row_t mk_row(input func_e f, input int b, input int r,
                                       input int c, input int mv, input int s,
                                       input int wt, input int x, input int y,
                                       input int z, input bit last, input bit typed,
                                       input int ex, input int ey, input int ez);
    skin_row_t row;
    row.item = '{f, 5'(b), 2'(r), 2'(c), mv, 2'(s), 16'(wt), x, y, z, last};
    row.typed = typed;
    row.want = '{ex, ey, ez, last};
    return row;
  endfunction

  // Presents one item and waits for it to be taken; predicts at acceptance.
  task automatic send_item(input skin_item_t it, input bit typed, input skin_out_t want);
    int unsigned gap;
    skin_out_t   res;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func <= it.func;
    bone_index <= it.bone;
    matrix_row <= it.row;
    matrix_col <= it.col;
    matrix_value <= it.mval;
    influence_slot <= it.slot;
    influence_weight <= it.wt;
    pos_x <= it.px;
    pos_y <= it.py;
    pos_z <= it.pz;
    batch_end <= it.last;
    do @(posedge clk_i); while (!in_ready);
    if (skin_vertex(it, res)) pending_vertices.push_back(typed ? want : res);
  endtask

  // Result side: random stalls, one long hold on request, checks in order.
  initial begin
    int unsigned gap;
    bit          quiet;
    skin_out_t   want;
    quiet = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d z=%0d last=%0b",
                                       out_x, out_y, out_z, out_last);
      end else begin
        want = pending_vertices.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                     want.x, want.y, want.z, want.last, out_x, out_y, out_z, out_last);
        end
      end
    end
  end

  initial begin
    skin_row_t  dir_rows[$];
    skin_item_t it;
    skin_out_t  none;
    int         f;
    none = '{default: '0};
    foreach (palette[i]) palette[i] = '0;
    foreach (infl_bone[k]) begin
      infl_bone[k] = '0;
      infl_wt[k] = '0;
    end

    // Bone 0 becomes the identity, so a full-weight vertex passes through.
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        dir_rows.push_back(mk_row(FUNC_LOAD, 0, r, c, (r == c) ? 65536 : 0, 0, 0,
                                  0, 0, 0, 0, 0, 0, 0, 0));
    // Row three must not land anywhere.
    dir_rows.push_back(mk_row(FUNC_LOAD, 0, 3, 0, 32'h12345678, 0, 0, 0, 0, 0, 0, 0,
                              0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_INFLUENCE, 0, 0, 0, 0, 0, 32768, 0, 0, 0, 0, 0,
                              0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_VERTEX, 31, 3, 3, 0, 3, 0, 32'h7FFFFFFF,
                              32'h80000000, 0, 1, 1, 32'h7FFFFFFF, 32'h80000000, 0));
    dir_rows.push_back(mk_row(FUNC_VERTEX, 0, 0, 0, 0, 0, 0, 32'h80000000,
                              32'h7FFFFFFF, 1, 0, 1, 32'h80000000, 32'h7FFFFFFF, 1));
    dir_rows.push_back(mk_row(FUNC_NONE, 31, 3, 3, -1, 3, 65535, -1, -1, -1, 1, 0,
                              0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_INFLUENCE, 0, 0, 0, 0, 3, 65535, 0, 0, 0, 0, 0,
                              0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_VERTEX, 0, 0, 0, 0, 0, 0, 32'h00010000,
                              32'hFFFF0000, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 0, 0, 3, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0,
                              0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_LOAD, 0, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0,
                              0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_VERTEX, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_INFLUENCE, 0, 0, 0, 0, 2, 32768, 0, 0, 0, 0, 0,
                              0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_VERTEX, 0, 0, 0, 0, 0, 0, 32'h80000000,
                              32'h80000000, 32'h80000000, 1, 0, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Every palette word is written before random vertices may read it.
    for (int b = 0; b < NumBonesDef; b++)
      for (int w = 0; w < BoneWords; w++) begin
        it = rand_item(FUNC_LOAD);
        it.bone = 5'(b);
        it.row = 2'(w / RowWords);
        it.col = 2'(w % RowWords);
        send_item(it, 1'b0, none);
      end

    for (int n = 0; n < 1300; n++) begin
      if (n % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n == 400) hold_req = 1'b1;
      if (n == 800) begin
        in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      f = $urandom_range(0, 99);
      if (n >= 400 && n < 440) f = 99;
      if (f < 30) it = rand_item(FUNC_LOAD);
      else if (f < 50) it = rand_item(FUNC_INFLUENCE);
      else if (f < 55) it = rand_item(FUNC_NONE);
      else it = rand_item(FUNC_VERTEX);
      send_item(it, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fbvs_pkg.sv
design/fbvs_ram.sv
design/four_bone_vertex_skinning.sv
dv/four_bone_vertex_skinning_tb.sv
